### hdl/jcl_pkg.sv
`timescale 1ns / 1ps

package jcl_pkg;

  // Field widths
  localparam int AXIS_W     = 12;
  localparam int POS_X_W    = 7;
  localparam int POS_Y_W    = 6;
  localparam int LEVEL_W    = 16;
  localparam int TIME_W     = 32;
  localparam int BTN_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Axis clamp window
  localparam logic [AXIS_W-1:0] AXIS_LO    = 12'd22;
  localparam logic [AXIS_W-1:0] AXIS_HI    = 12'd4090;
  localparam logic [AXIS_W-1:0] AXIS_RANGE = 12'd4068;

  // Screen geometry defaults and border inset
  localparam int SCREEN_W_DEF    = 128;
  localparam int SCREEN_H_DEF    = 64;
  localparam int CURSOR_SIZE_DEF = 8;
  localparam int INSET           = 5;

  // Reset values
  localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST = 32'd200000;
  localparam logic [AXIS_W-1:0]     CENTER_X_RST = 12'd2147;
  localparam logic [AXIS_W-1:0]     CENTER_Y_RST = 12'd1890;
  localparam logic [POS_X_W-1:0]    POS_X_RST    = 7'd60;
  localparam logic [POS_Y_W-1:0]    POS_Y_RST    = 6'd28;

  // Shared divider: restoring, two quotient bits per cycle
  localparam int DIV_NUM_W = 28;
  localparam int DIV_DEN_W = AXIS_W;
  localparam int DIV_STEPS = 2;
  localparam int DIV_CYC   = DIV_NUM_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_CYC + 1);

  // Codes
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_PRESS  = 1'b1
  } op_e;

  localparam logic [BTN_W-1:0] BTN_JOY = 2'd0;
  localparam logic [BTN_W-1:0] BTN_A   = 2'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd2;

  typedef struct packed {
    logic               operation;
    logic [AXIS_W-1:0]  stick_x;
    logic [AXIS_W-1:0]  stick_y;
    logic [BTN_W-1:0]   button_id;
    logic [TIME_W-1:0]  time_us;
  } in_t;

  typedef struct packed {
    logic [POS_X_W-1:0] cursor_x;
    logic [POS_Y_W-1:0] cursor_y;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] blue_level;
    logic               border_on;
    logic               pwm_on;
    logic               press_accepted;
  } out_t;

  // Top to lane: one axis job. span is two's complement.
  typedef struct packed {
    logic               start;
    logic [AXIS_W-1:0]  raw;
    logic [AXIS_W-1:0]  centre;
    logic [POS_X_W-1:0] lo;
    logic [AXIS_W-1:0]  span;
  } lane_cmd_t;

  // Lane to top: done pulse plus held results
  typedef struct packed {
    logic               done;
    logic [POS_X_W-1:0] pos;
    logic [LEVEL_W-1:0] level;
  } lane_res_t;

endpackage

### hdl/jcl_div.sv
`timescale 1ns / 1ps

module jcl_div import jcl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic                 done_o,
  output logic [DIV_NUM_W-1:0] quo_o
);

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_DEN_W:0]   rem_q, rem_d;
  logic [DIV_NUM_W-1:0] quo_q, quo_d;
  logic [DIV_DEN_W-1:0] den_q;

  // two restoring steps per cycle
  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_d = {rem_d[DIV_DEN_W-1:0], quo_d[DIV_NUM_W-1]};
      quo_d = {quo_d[DIV_NUM_W-2:0], 1'b0};
      if (rem_d >= {1'b0, den_q}) begin
        rem_d    = rem_d - {1'b0, den_q};
        quo_d[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(DIV_CYC);
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= num_i;
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

### hdl/jcl_lane.sv
`timescale 1ns / 1ps

module jcl_lane import jcl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  lane_cmd_t cmd_i,
  output lane_res_t res_o
);

  typedef enum logic [2:0] {
    L_IDLE = 3'b001,
    L_POS  = 3'b010,
    L_LVL  = 3'b100
  } lane_state_e;

  lane_state_e state_q, state_d;

  logic [AXIS_W-1:0]    clamped, off, mag, dev, lvl_den;
  logic [2*AXIS_W-1:0]  prod;
  logic [DIV_NUM_W-1:0] lvl_num, div_num, div_quo;
  logic [DIV_DEN_W-1:0] div_den;
  logic                 div_start, div_done, neg;
  logic [POS_X_W-1:0]   q_low, pos_d, pos_q;
  logic [LEVEL_W-1:0]   level_d, level_q;
  logic                 done_q;

  // position: clamp, then (v - lo) * |span| / range, sign applied after
  always_comb begin
    if (cmd_i.raw < AXIS_LO) begin
      clamped = AXIS_LO;
    end else if (cmd_i.raw > AXIS_HI) begin
      clamped = AXIS_HI;
    end else begin
      clamped = cmd_i.raw;
    end
    off  = clamped - AXIS_LO;
    neg  = cmd_i.span[AXIS_W-1];
    mag  = neg ? (AXIS_W'(0) - cmd_i.span) : cmd_i.span;
    prod = {{AXIS_W{1'b0}}, off} * {{AXIS_W{1'b0}}, mag};
  end

  // level: |raw - centre| * 65535 / max(centre, 1), on unclamped reading
  always_comb begin
    dev     = (cmd_i.raw >= cmd_i.centre) ? (cmd_i.raw - cmd_i.centre)
                                          : (cmd_i.centre - cmd_i.raw);
    lvl_num = {dev, {LEVEL_W{1'b0}}} - {{LEVEL_W{1'b0}}, dev};
    lvl_den = (cmd_i.centre == '0) ? AXIS_W'(1) : cmd_i.centre;
  end

  assign div_start = ((state_q == L_IDLE) && cmd_i.start) ||
                     ((state_q == L_POS) && div_done);
  assign div_num   = (state_q == L_IDLE) ? DIV_NUM_W'(prod) : lvl_num;
  assign div_den   = (state_q == L_IDLE) ? AXIS_RANGE : lvl_den;

  jcl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // quotient magnitude is truncated, so negating the low bits is exact mod 2^7
  assign q_low   = div_quo[POS_X_W-1:0];
  assign pos_d   = cmd_i.lo + (neg ? (POS_X_W'(0) - q_low) : q_low);
  assign level_d = (div_quo[DIV_NUM_W-1:LEVEL_W] != '0) ? {LEVEL_W{1'b1}}
                                                        : div_quo[LEVEL_W-1:0];

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE: if (cmd_i.start) state_d = L_POS;
      L_POS:  if (div_done) state_d = L_LVL;
      L_LVL:  if (div_done) state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == L_LVL) && div_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == L_POS) && div_done) pos_q <= pos_d;
    if ((state_q == L_LVL) && div_done) level_q <= level_d;
  end

  assign res_o.done  = done_q;
  assign res_o.pos   = pos_q;
  assign res_o.level = level_q;

endmodule

### hdl/joystick_cursor_and_led_drive.sv
`timescale 1ns / 1ps

// Joystick cursor and LED drive.
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction is a
// joystick sample or a button press. Output channel (out_valid_o /
// out_stall_i / out_data_o): exactly one transaction per input, carrying the
// cursor position, both LED levels, the mode flags and the debounce verdict.
// Config port: cfg_we_i writes cfg_wdata_i into register cfg_idx_i
// (0 debounce_us, 1 center_x, 2 center_y); other indexes are ignored.
// Sequencing: a sample runs two lanes (X, Y) side by side, each doing two
// back-to-back divisions on its own shared radix-4 divider; a press needs
// no division. One item is in flight at a time; the next is taken the
// cycle after the result is loaded into the output register. A result
// waiting under out_stall_i does not block acceptance of the next item;
// only its completion waits for the output register to free.
// Reset: config returns to 200000 / 2147 / 1890, border off, PWM on,
// cursor at 60,28, levels 0, last press time 0, both channels empty.

module joystick_cursor_and_led_drive import jcl_pkg::*; #(
  parameter int SCREEN_W    = SCREEN_W_DEF,
  parameter int SCREEN_H    = SCREEN_H_DEF,
  parameter int CURSOR_SIZE = CURSOR_SIZE_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  in_t                   in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output out_t                  out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Mapping endpoints. lo is the value at the low axis reading, span is
  // (high end - low end); Y runs top-down so its span is negative.
  localparam int SPAN_X_N = SCREEN_W - CURSOR_SIZE;
  localparam int SPAN_X_B = SCREEN_W - CURSOR_SIZE - 2 * INSET;
  localparam int LO_Y_N   = SCREEN_H - CURSOR_SIZE;
  localparam int LO_Y_B   = SCREEN_H - CURSOR_SIZE - INSET;
  localparam int SPAN_Y_N = CURSOR_SIZE - SCREEN_H;
  localparam int SPAN_Y_B = CURSOR_SIZE + 2 * INSET - SCREEN_H;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_START = 4'b0010,
    S_LANE  = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  in_t item_q;

  // configuration
  logic [CFG_DATA_W-1:0] debounce_q;
  logic [AXIS_W-1:0]     center_x_q, center_y_q;

  // architectural state
  logic                  border_q, border_d;
  logic                  pwm_q, pwm_d;
  logic [TIME_W-1:0]     last_q, last_d;
  logic [POS_X_W-1:0]    pos_x_q, pos_x_d;
  logic [POS_Y_W-1:0]    pos_y_q, pos_y_d;
  logic [LEVEL_W-1:0]    red_q, red_d;
  logic [LEVEL_W-1:0]    blue_q, blue_d;

  // output register
  logic                  out_valid_q;
  out_t                  out_q, out_d;

  logic                  accept, out_free, commit, lane_start, accepted;
  logic [TIME_W-1:0]     gap;
  lane_cmd_t             cmd_x, cmd_y;
  lane_res_t             res_x, res_y;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign commit     = (state_q == S_FIN) && out_free;
  assign lane_start = (state_q == S_START) && (item_q.operation == OP_SAMPLE);

  // ---- lanes: X and Y axes in parallel ----
  always_comb begin
    cmd_x.start  = lane_start;
    cmd_x.raw    = item_q.stick_x;
    cmd_x.centre = center_x_q;
    cmd_x.lo     = border_q ? POS_X_W'(INSET) : '0;
    cmd_x.span   = border_q ? AXIS_W'(SPAN_X_B) : AXIS_W'(SPAN_X_N);

    cmd_y.start  = lane_start;
    cmd_y.raw    = item_q.stick_y;
    cmd_y.centre = center_y_q;
    cmd_y.lo     = border_q ? POS_X_W'(LO_Y_B) : POS_X_W'(LO_Y_N);
    cmd_y.span   = border_q ? AXIS_W'(SPAN_Y_B) : AXIS_W'(SPAN_Y_N);
  end

  jcl_lane u_lane_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_x),
    .res_o  (res_x)
  );

  jcl_lane u_lane_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_y),
    .res_o  (res_y)
  );

  // ---- sequencer ----
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = S_START;
      S_START: state_d = (item_q.operation == OP_SAMPLE) ? S_LANE : S_FIN;
      S_LANE:  if (res_x.done && res_y.done) state_d = S_FIN;  // lanes run in lockstep, both done in the same cycle
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---- merge: fold lane results / press into state, build the result ----
  assign gap = item_q.time_us - last_q;  // wraps mod 2^32

  always_comb begin
    border_d = border_q;
    pwm_d    = pwm_q;
    last_d   = last_q;
    pos_x_d  = pos_x_q;
    pos_y_d  = pos_y_q;
    red_d    = red_q;
    blue_d   = blue_q;
    accepted = 1'b0;
    if (commit) begin
      if (item_q.operation == OP_SAMPLE) begin
        pos_x_d = res_x.pos;
        pos_y_d = res_y.pos[POS_Y_W-1:0];
        // levels hold while PWM is off
        if (pwm_q) begin
          red_d  = res_x.level;
          blue_d = res_y.level;
        end
      end else if (gap > debounce_q) begin
        accepted = 1'b1;
        last_d   = item_q.time_us;
        case (item_q.button_id)
          BTN_JOY: border_d = ~border_q;
          BTN_A: begin
            pwm_d = ~pwm_q;
            if (pwm_q) begin
              red_d  = '0;
              blue_d = '0;
            end
          end
          default: ;  // other pins: debounce only
        endcase
      end
    end
  end

  always_comb begin
    out_d.cursor_x       = pos_x_d;
    out_d.cursor_y       = pos_y_d;
    out_d.red_level      = red_d;
    out_d.blue_level     = blue_d;
    out_d.border_on      = border_d;
    out_d.pwm_on         = pwm_d;
    out_d.press_accepted = accepted;
  end

  // ---- registers ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      debounce_q  <= DEBOUNCE_RST;
      center_x_q  <= CENTER_X_RST;
      center_y_q  <= CENTER_Y_RST;
      border_q    <= 1'b0;
      pwm_q       <= 1'b1;
      last_q      <= '0;
      pos_x_q     <= POS_X_RST;
      pos_y_q     <= POS_Y_RST;
      red_q       <= '0;
      blue_q      <= '0;
    end else begin
      state_q  <= state_d;
      border_q <= border_d;
      pwm_q    <= pwm_d;
      last_q   <= last_d;
      pos_x_q  <= pos_x_d;
      pos_y_q  <= pos_y_d;
      red_q    <= red_d;
      blue_q   <= blue_d;

      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_DEBOUNCE: debounce_q <= cfg_wdata_i;
          CFG_CENTER_X: center_x_q <= cfg_wdata_i[AXIS_W-1:0];
          CFG_CENTER_Y: center_y_q <= cfg_wdata_i[AXIS_W-1:0];
          default: ;  // unmapped index
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) item_q <= in_data_i;
    if (commit) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
